/* rtl/mscp_pkg.sv */
// ----------------------------------------------------------------------------
// Motor speed curve package
// Field widths, register codes and the side-band type shared by the
// speed-curve pipeline and its quotient unit.
// ----------------------------------------------------------------------------
package mscp_pkg;

   // Width of one command or breakpoint field, two's complement.
   localparam int FIELD_W = 12;
   // Curve registers hold up to five packed breakpoints.
   localparam int REG_W = 60;
   localparam int MAX_POINTS = REG_W / FIELD_W;
   // Duty outputs and the rounded scale factor.
   localparam int DUTY_W = 8;
   localparam int FULL_SCALE = 255;
   localparam int QUOT_W = DUTY_W;

   // Configuration bus geometry: two 64-bit registers at byte offsets 0 and 8.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   // Register codes, taken from the doubleword bit of the address.
   typedef enum logic {
      CSR_CURVE_X = 1'b0,
      CSR_CURVE_Y = 1'b1
   } csr_reg_type;

   // Flags that ride along with an item through the quotient unit.
   typedef struct packed {
      logic cmd_pos;
      logic cmd_neg;
      logic num_neg;
   } div_tag_type;

endpackage

/* rtl/mscp_req_if.sv */
// ----------------------------------------------------------------------------
// Speed command channel
// Valid/ready channel that carries one signed speed command per beat.
// ----------------------------------------------------------------------------
interface mscp_req_if;

   logic                                 valid;
   logic                                 ready;
   logic signed [mscp_pkg::FIELD_W-1:0]  speed_command;

   modport source (output valid, output speed_command, input ready);
   modport sink (input valid, input speed_command, output ready);

endinterface

/* rtl/mscp_rsp_if.sv */
// ----------------------------------------------------------------------------
// PWM duty channel
// Valid/ready channel that carries the forward and backward duties per beat.
// ----------------------------------------------------------------------------
interface mscp_rsp_if;

   logic                           valid;
   logic                           ready;
   logic [mscp_pkg::DUTY_W-1:0]    forward_duty;
   logic [mscp_pkg::DUTY_W-1:0]    backward_duty;

   modport source (output valid, output forward_duty, output backward_duty, input ready);
   modport sink (input valid, input forward_duty, input backward_duty, output ready);

endinterface

/* rtl/mscp_div.sv */
// ----------------------------------------------------------------------------
// Pipelined rounding quotient unit
// Restoring division with one quotient bit per register stage. The caller
// guarantees that the quotient fits in QUOT_W bits. Each stage stalls on its
// own, so bubbles collapse while the output is held.
// ----------------------------------------------------------------------------
module mscp_div #(
   parameter int FRAC_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [FRAC_BITS+mscp_pkg::FIELD_W+9:0] in_dividend,
   input  logic [FRAC_BITS+mscp_pkg::FIELD_W:0]   in_divisor,
   input  mscp_pkg::div_tag_type                  in_tag,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [mscp_pkg::QUOT_W-1:0]            out_quot,
   output mscp_pkg::div_tag_type                  out_tag
);

   localparam int DIVIDEND_W = FRAC_BITS + mscp_pkg::FIELD_W + 10;
   localparam int DIVISOR_W = FRAC_BITS + mscp_pkg::FIELD_W + 1;
   localparam int QUOT_W = mscp_pkg::QUOT_W;
   localparam int LAST = QUOT_W - 1;

   // Stage registers, one quotient bit resolved per stage.
   logic                  valid_ff [QUOT_W];
   logic [DIVIDEND_W-1:0] rem_ff [QUOT_W];
   logic [DIVISOR_W-1:0]  dvs_ff [QUOT_W];
   logic [QUOT_W-1:0]     quot_ff [QUOT_W];
   mscp_pkg::div_tag_type tag_ff [QUOT_W];

   // Values entering each stage and their next register contents.
   logic                  valid_src [QUOT_W];
   logic [DIVIDEND_W-1:0] rem_src [QUOT_W];
   logic [DIVISOR_W-1:0]  dvs_src [QUOT_W];
   logic [QUOT_W-1:0]     quot_src [QUOT_W];
   mscp_pkg::div_tag_type tag_src [QUOT_W];
   logic [DIVIDEND_W-1:0] trial [QUOT_W];
   logic                  fits [QUOT_W];
   logic [DIVIDEND_W-1:0] rem_in [QUOT_W];
   logic [QUOT_W-1:0]     quot_in [QUOT_W];
   logic [QUOT_W:0]       stage_en;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      stage_en[QUOT_W] = out_ready;
      for (int i = QUOT_W - 1; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   // Stage inputs come from the port for the first stage, else the stage before.
   always_comb begin
      valid_src[0] = in_valid;
      rem_src[0] = in_dividend;
      dvs_src[0] = in_divisor;
      quot_src[0] = '0;
      tag_src[0] = in_tag;
      for (int i = 1; i < QUOT_W; i++) begin
         valid_src[i] = valid_ff[i-1];
         rem_src[i] = rem_ff[i-1];
         dvs_src[i] = dvs_ff[i-1];
         quot_src[i] = quot_ff[i-1];
         tag_src[i] = tag_ff[i-1];
      end
   end

   // Compare the partial remainder with the shifted divisor and subtract.
   always_comb begin
      for (int i = 0; i < QUOT_W; i++) begin
         trial[i] = DIVIDEND_W'(dvs_src[i]) << (LAST - i);
         fits[i] = rem_src[i] >= trial[i];
         rem_in[i] = fits[i] ? rem_src[i] - trial[i] : rem_src[i];
         quot_in[i] = quot_src[i];
         quot_in[i][LAST-i] = fits[i];
      end
   end

   // Valid bits are cleared by reset; the data registers are not.
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUOT_W; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_en[i]) begin
            valid_ff[i] <= valid_src[i];
         end
         if (stage_en[i]) begin
            rem_ff[i] <= rem_in[i];
            dvs_ff[i] <= dvs_src[i];
            quot_ff[i] <= quot_in[i];
            tag_ff[i] <= tag_src[i];
         end
      end
   end

   assign in_ready = stage_en[0];
   assign out_valid = valid_ff[LAST];
   assign out_quot = quot_ff[LAST];
   assign out_tag = tag_ff[LAST];

   // The final remainder is below the divisor, so the quotient is complete.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |-> (rem_ff[LAST] < DIVIDEND_W'(dvs_ff[LAST])))
      else $error("quotient unit: final remainder not below divisor");

   // A beat taken at the input occupies the first stage next cycle.
   a_take_fills_first: assert property (@(posedge clock) disable iff (reset)
      (in_valid && stage_en[0]) |=> valid_ff[0])
      else $error("quotient unit: accepted beat lost at first stage");

   // A held result keeps its quotient while the consumer stalls.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[LAST] && !out_ready) |=> (valid_ff[LAST] && $stable(quot_ff[LAST])))
      else $error("quotient unit: stalled result changed");

endmodule

/* rtl/motor_speed_curve_to_pwm_unit.sv */
// The unit takes one speed command per clock cycle while the output is not
// stalled and returns one pair of H-bridge duties per command, in order,
// through five arithmetic stages (segment search, products, sum, clamp,
// dividend), eight quotient stages that each resolve one bit of the rounded
// 8-bit duty, and the output register. Each stage holds its item
// independently, so bubbles close up while a result waits to be taken. The
// curve breakpoints are programmed through the register port and are
// expected to be stable while commands are in flight.
// ----------------------------------------------------------------------------
// Motor speed curve to PWM unit
// Piecewise-linear correction of a signed speed command, clamped to full
// scale, rounded to an 8-bit duty and steered to the forward or backward pin.
// ----------------------------------------------------------------------------
module motor_speed_curve_to_pwm_unit #(
   parameter int NUM_POINTS = 5,
   parameter int FRAC_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   mscp_req_if.sink                            req_bus,
   mscp_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mscp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mscp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mscp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int FIELD_W = mscp_pkg::FIELD_W;
   localparam int REG_W = mscp_pkg::REG_W;
   localparam int DUTY_W = mscp_pkg::DUTY_W;
   localparam int SEG_W = $clog2(NUM_POINTS);
   localparam int DIFF_W = FIELD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int NUM_W = PROD_W + 1;
   localparam int DEN_W = FIELD_W;
   localparam int MAG_W = DEN_W + FRAC_BITS;
   localparam int DIVIDEND_W = MAG_W + 10;
   localparam int DIVISOR_W = MAG_W + 1;
   localparam int One = 1 << FRAC_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [REG_W-1:0]         default_curve;
   logic [REG_W-1:0]         curve_x_ff;
   logic [REG_W-1:0]         curve_y_ff;
   logic [REG_W-1:0]         curve_x_in;
   logic [REG_W-1:0]         curve_y_in;
   logic                     csr_write;
   mscp_pkg::csr_reg_type    csr_reg;

   // Reset curve: evenly spaced points from minus one to plus one.
   for (genvar k = 0; k < mscp_pkg::MAX_POINTS; k++) begin : g_default
      if (k < NUM_POINTS) begin : g_used
         localparam int Val = -One + (2 * One * k) / (NUM_POINTS - 1);
         assign default_curve[FIELD_W*k +: FIELD_W] = FIELD_W'(Val);
      end else begin : g_unused
         assign default_curve[FIELD_W*k +: FIELD_W] = '0;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg = mscp_pkg::csr_reg_type'(csr_paddr[mscp_pkg::CSR_ADDR_W-1]);
   assign csr_pready = 1'b1;

   // Register write decode.
   always_comb begin
      curve_x_in = curve_x_ff;
      curve_y_in = curve_y_ff;
      if (csr_write) begin
         unique case (csr_reg)
            mscp_pkg::CSR_CURVE_X: curve_x_in = csr_pwdata[REG_W-1:0];
            mscp_pkg::CSR_CURVE_Y: curve_y_in = csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read decode.
   always_comb begin
      unique case (csr_reg)
         mscp_pkg::CSR_CURVE_X: csr_prdata = mscp_pkg::CSR_DATA_W'(curve_x_ff);
         mscp_pkg::CSR_CURVE_Y: csr_prdata = mscp_pkg::CSR_DATA_W'(curve_y_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_x_ff <= default_curve;
         curve_y_ff <= default_curve;
      end else begin
         curve_x_ff <= curve_x_in;
         curve_y_ff <= curve_y_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stall chain: a stage loads when it is empty or its item moves on.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, s5_en, out_en;
   logic div_in_ready, div_out_valid;
   logic rsp_valid_ff;

   assign out_en = !rsp_valid_ff || rsp_bus.ready;
   assign s5_en = !s5_valid_ff || div_in_ready;
   assign s4_en = !s4_valid_ff || s5_en;
   assign s3_en = !s3_valid_ff || s4_en;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_bus.ready = s1_en;

   // ---------------------------------------------------------------------
   // Stage 1: segment search and differences
   // ---------------------------------------------------------------------
   logic signed [FIELD_W-1:0] x_pt [NUM_POINTS];
   logic signed [FIELD_W-1:0] y_pt [NUM_POINTS];
   logic signed [FIELD_W-1:0] cmd;
   logic [SEG_W-1:0]          seg;
   logic signed [FIELD_W-1:0] x0, x1, y0, y1;
   logic signed [DIFF_W-1:0]  s1_dx_in, s1_dxx_in, s1_dy_in;
   logic signed [DIFF_W-1:0]  s1_dx_ff, s1_dxx_ff, s1_dy_ff;
   logic signed [FIELD_W-1:0] s1_y0_ff;
   mscp_pkg::div_tag_type     s1_tag_in, s1_tag_ff;

   assign cmd = req_bus.speed_command;

   // Unpack the breakpoints that are in use.
   always_comb begin
      for (int k = 0; k < NUM_POINTS; k++) begin
         x_pt[k] = curve_x_ff[FIELD_W*k +: FIELD_W];
         y_pt[k] = curve_y_ff[FIELD_W*k +: FIELD_W];
      end
   end

   // The first interior breakpoint above the command picks the segment;
   // past the last one the final segment is extended.
   always_comb begin
      seg = SEG_W'(NUM_POINTS - 2);
      for (int j = NUM_POINTS - 2; j >= 1; j--) begin
         if (cmd < x_pt[j]) begin
            seg = SEG_W'(j - 1);
         end
      end
   end

   // Select the segment end points.
   always_comb begin
      x0 = x_pt[0];
      x1 = x_pt[1];
      y0 = y_pt[0];
      y1 = y_pt[1];
      for (int k = 0; k < NUM_POINTS - 1; k++) begin
         if (seg == SEG_W'(k)) begin
            x0 = x_pt[k];
            x1 = x_pt[k+1];
            y0 = y_pt[k];
            y1 = y_pt[k+1];
         end
      end
   end

   assign s1_dx_in = DIFF_W'(x1) - DIFF_W'(x0);
   assign s1_dxx_in = DIFF_W'(cmd) - DIFF_W'(x0);
   assign s1_dy_in = DIFF_W'(y1) - DIFF_W'(y0);
   assign s1_tag_in.cmd_pos = !cmd[FIELD_W-1] && (cmd != '0);
   assign s1_tag_in.cmd_neg = cmd[FIELD_W-1];
   assign s1_tag_in.num_neg = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (s1_en) begin
         s1_dx_ff <= s1_dx_in;
         s1_dxx_ff <= s1_dxx_in;
         s1_dy_ff <= s1_dy_in;
         s1_y0_ff <= y0;
         s1_tag_ff <= s1_tag_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: interpolation products
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0]  s2_p1_in, s2_p2_in, s2_p1_ff, s2_p2_ff;
   logic signed [DIFF_W-1:0]  s2_dx_ff;
   logic signed [FIELD_W-1:0] s2_y0_ff;
   mscp_pkg::div_tag_type     s2_tag_ff;

   assign s2_p1_in = PROD_W'(s1_dxx_ff) * PROD_W'(s1_dy_ff);
   assign s2_p2_in = PROD_W'(s1_y0_ff) * PROD_W'(s1_dx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_en) begin
         s2_p1_ff <= s2_p1_in;
         s2_p2_ff <= s2_p2_in;
         s2_dx_ff <= s1_dx_ff;
         s2_y0_ff <= s1_y0_ff;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: numerator and positive denominator
   // ---------------------------------------------------------------------
   logic signed [NUM_W-1:0] sum;
   logic signed [NUM_W-1:0] s3_num_in, s3_num_ff;
   logic [DEN_W-1:0]        s3_den_in, s3_den_ff;
   mscp_pkg::div_tag_type   s3_tag_ff;

   assign sum = NUM_W'(s2_p1_ff) + NUM_W'(s2_p2_ff);

   // A zero-width segment yields its start y over a unit denominator;
   // a descending segment moves its sign into the numerator.
   always_comb begin
      if (s2_dx_ff == '0) begin
         s3_num_in = NUM_W'(s2_y0_ff);
         s3_den_in = DEN_W'(1);
      end else if (s2_dx_ff < 0) begin
         s3_num_in = -sum;
         s3_den_in = DEN_W'(-s2_dx_ff);
      end else begin
         s3_num_in = sum;
         s3_den_in = DEN_W'(s2_dx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_en) begin
         s3_num_ff <= s3_num_in;
         s3_den_ff <= s3_den_in;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: magnitude clamped to full scale
   // ---------------------------------------------------------------------
   logic [NUM_W-1:0]      num_mag;
   logic [MAG_W-1:0]      limit;
   logic [MAG_W-1:0]      s4_mag_in, s4_mag_ff;
   logic [DEN_W-1:0]      s4_den_ff;
   mscp_pkg::div_tag_type s4_tag_in, s4_tag_ff;

   assign num_mag = s3_num_ff[NUM_W-1] ? NUM_W'(-s3_num_ff) : NUM_W'(s3_num_ff);
   assign limit = MAG_W'(s3_den_ff) << FRAC_BITS;
   assign s4_mag_in = (num_mag > NUM_W'(limit)) ? limit : MAG_W'(num_mag);

   always_comb begin
      s4_tag_in = s3_tag_ff;
      s4_tag_in.num_neg = s3_num_ff[NUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_en) begin
         s4_mag_ff <= s4_mag_in;
         s4_den_ff <= s3_den_ff;
         s4_tag_ff <= s4_tag_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: rounding dividend and divisor
   // The duty is floor((2 * 255 * mag + one * den) / (2 * one * den)).
   // ---------------------------------------------------------------------
   logic [DIVIDEND_W-1:0] s5_dividend_in, s5_dividend_ff;
   logic [DIVISOR_W-1:0]  s5_divisor_in, s5_divisor_ff;
   mscp_pkg::div_tag_type s5_tag_ff;

   assign s5_dividend_in = DIVIDEND_W'(s4_mag_ff) * DIVIDEND_W'(2 * mscp_pkg::FULL_SCALE)
                         + (DIVIDEND_W'(s4_den_ff) << FRAC_BITS);
   assign s5_divisor_in = DIVISOR_W'(s4_den_ff) << (FRAC_BITS + 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_en) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (s5_en) begin
         s5_dividend_ff <= s5_dividend_in;
         s5_divisor_ff <= s5_divisor_in;
         s5_tag_ff <= s4_tag_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Quotient stages
   // ---------------------------------------------------------------------
   logic [mscp_pkg::QUOT_W-1:0] div_quot;
   mscp_pkg::div_tag_type       div_tag;

   mscp_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s5_valid_ff),
      .in_ready    (div_in_ready),
      .in_dividend (s5_dividend_ff),
      .in_divisor  (s5_divisor_ff),
      .in_tag      (s5_tag_ff),
      .out_valid   (div_out_valid),
      .out_ready   (out_en),
      .out_quot    (div_quot),
      .out_tag     (div_tag)
   );

   // ---------------------------------------------------------------------
   // Output register: steer the duty to the pin the command selects.
   // A curve value of the wrong sign leaves the driven pin at zero.
   // ---------------------------------------------------------------------
   logic [DUTY_W-1:0] rsp_forward_in, rsp_backward_in;
   logic [DUTY_W-1:0] rsp_forward_ff, rsp_backward_ff;

   assign rsp_forward_in = (div_tag.cmd_pos && !div_tag.num_neg) ? div_quot : '0;
   assign rsp_backward_in = (div_tag.cmd_neg && div_tag.num_neg) ? div_quot : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= div_out_valid;
      end
      if (out_en) begin
         rsp_forward_ff <= rsp_forward_in;
         rsp_backward_ff <= rsp_backward_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.forward_duty = rsp_forward_ff;
   assign rsp_bus.backward_duty = rsp_backward_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // An accepted beat is present in the first stage on the next cycle.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> s1_valid_ff)
      else $error("speed curve: accepted command lost at first stage");

   // The clamped magnitude never exceeds full scale for its denominator.
   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_mag_ff <= (MAG_W'(s4_den_ff) << FRAC_BITS)))
      else $error("speed curve: clamped magnitude above full scale");

   // Both pins are never driven at once.
   a_one_pin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_forward_ff == '0 || rsp_backward_ff == '0))
      else $error("speed curve: forward and backward duty both nonzero");

   // A write to the breakpoint input register takes the written data.
   a_curve_x_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_reg == mscp_pkg::CSR_CURVE_X)
      |=> (curve_x_ff == $past(csr_pwdata[REG_W-1:0])))
      else $error("speed curve: breakpoint register write not taken");

endmodule
